### rtl/core/ecsm_pkg.sv
// Shared types, micro-operation codes and defaults for the EC scalar multiply block.
package ecsm_pkg;

  localparam int WORD_BITS_DEF   = 64;
  localparam int SCALAR_BITS_DEF = 64;
  localparam int PADDR_BITS      = 4;

  // Datapath operations
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SUB   = 3'd2;
  localparam logic [2:0] OP_MOV   = 3'd3;
  localparam logic [2:0] OP_MUL   = 3'd4;
  localparam logic [2:0] OP_DIV   = 3'd5;
  localparam logic [2:0] OP_OUTOK = 3'd6;
  localparam logic [2:0] OP_OUTFL = 3'd7;

  // Operand and destination codes
  localparam logic [4:0] R_PX   = 5'd0;
  localparam logic [4:0] R_PY   = 5'd1;
  localparam logic [4:0] R_BX   = 5'd2;
  localparam logic [4:0] R_BY   = 5'd3;
  localparam logic [4:0] R_S    = 5'd4;
  localparam logic [4:0] R_T    = 5'd5;
  localparam logic [4:0] R_U    = 5'd6;
  localparam logic [4:0] R_R0   = 5'd7;
  localparam logic [4:0] R_R1   = 5'd8;
  localparam logic [4:0] R_T0   = 5'd9;
  localparam logic [4:0] R_T1   = 5'd10;
  localparam logic [4:0] R_Q    = 5'd11;
  localparam logic [4:0] R_A    = 5'd12;
  localparam logic [4:0] R_N    = 5'd13;
  localparam logic [4:0] R_ZERO = 5'd14;
  localparam logic [4:0] R_ONE  = 5'd15;
  localparam logic [4:0] R_IX   = 5'd16;
  localparam logic [4:0] R_IY   = 5'd17;

  typedef struct packed {
    logic       go;
    logic [2:0] op;
    logic [4:0] src_a;
    logic [4:0] src_b;
    logic [4:0] dst;
    logic       set_inf;
    logic       clr_inf;
  } ecsm_cmd_t;

  typedef struct packed {
    logic done;
    logic pinf;
    logic py_zero;
    logic px_eq_bx;
    logic py_eq_by;
    logic r1_zero;
    logic r0_one;
  } ecsm_stat_t;

  typedef struct packed {
    logic [63:0] scalar;
    logic [63:0] base_x;
    logic [63:0] base_y;
  } ecsm_in_t;

  typedef struct packed {
    logic [63:0] result_x;
    logic [63:0] result_y;
    logic        at_infinity;
    logic [63:0] divisor;
    logic        factor_found;
  } ecsm_out_t;

endpackage

### rtl/core/weierstrass_scalar_multiply_mod_n.sv
// Top level of the elliptic curve scalar multiplier modulo N (factor search form).
//
// Usage: write the modulus N (byte address 0) and coefficient a (address 8) over
// the APB port while the block is idle; a modulus below 3 is stored as 3.
// Raise start with a request on in_req (scalar, base_x, base_y); it is taken
// when busy is low. Exactly one result follows on out_res, marked by a
// one-cycle out_strobe; busy drops in that same cycle, so the next request may
// be taken there. The receiver cannot stall: capture the result on the strobe.
// Run time depends on the data: each modular product runs in the shared serial
// multiplier, each quotient in the shared divider, and every inversion runs one
// divide and one product per extended gcd round; one request is worked at a time.
// On an inversion failure the result carries the gcd as divisor with
// factor_found set. Reset returns N to 3, a to 0 and the block to idle.
module weierstrass_scalar_multiply_mod_n import ecsm_pkg::*; #(
  parameter int WORD_BITS   = WORD_BITS_DEF,
  parameter int SCALAR_BITS = SCALAR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  ecsm_in_t              in_req,
  output logic                  out_strobe,
  output ecsm_out_t             out_res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  logic       accept;
  logic       cfg_wr;
  logic [63:0] n_val, a_val;
  ecsm_cmd_t  cmd;
  ecsm_stat_t stat;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[3] ? a_val : n_val;

  ecsm_ctrl #(.SCALAR_BITS(SCALAR_BITS)) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .scalar (in_req.scalar),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  ecsm_dpath #(.WORD_BITS(WORD_BITS)) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_load    (accept),
    .in_req     (in_req),
    .cfg_wr     (cfg_wr),
    .cfg_sel_a  (paddr[3]),
    .cfg_wdata  (pwdata),
    .n_val      (n_val),
    .a_val      (a_val),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

### rtl/core/ecsm_mulmod.sv
// Bit-serial modular multiplier: double and conditional add, one modular add per cycle.
module ecsm_mulmod import ecsm_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] op_a,
  input  logic [WORD_BITS-1:0] op_b,
  input  logic [WORD_BITS-1:0] modulus,
  output logic                 done,
  output logic [WORD_BITS-1:0] prod
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(W);

  logic [W-1:0]  acc_r;
  logic [W-1:0]  a_r;
  logic [W-1:0]  b_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          ph_r;
  logic          done_r;
  logic [W-1:0]  sum_dbl;
  logic [W-1:0]  sum_add;

  function automatic logic [W-1:0] addm(input logic [W-1:0] p, input logic [W-1:0] q,
                                         input logic [W-1:0] n);
    logic [W:0] s;
    s = {1'b0, p} + {1'b0, q};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[W-1:0];
  endfunction

  assign sum_dbl = addm(acc_r, acc_r, modulus);
  assign sum_add = addm(acc_r, a_r, modulus);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= 1'b0;
        acc_r  <= '0;
        a_r    <= op_a;
        b_r    <= op_b;
        cnt_r  <= CW'(W - 1);
      end else if (busy_r) begin
        if (!ph_r) begin
          acc_r <= sum_dbl;
        end else begin
          acc_r <= sum_add;
        end
        // add phase follows the doubling only for a set multiplier bit
        if (!ph_r && b_r[W-1]) begin
          ph_r <= 1'b1;
        end else begin
          ph_r <= 1'b0;
          b_r  <= {b_r[W-2:0], 1'b0};
          if (cnt_r == '0) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### rtl/core/ecsm_divu.sv
// Restoring divider, one quotient bit per cycle.
module ecsm_divu import ecsm_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] divisor,
  output logic                 done,
  output logic [WORD_BITS-1:0] quot,
  output logic [WORD_BITS-1:0] rem
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(W);

  logic [W-1:0]  rem_r;
  logic [W-1:0]  dq_r;
  logic [W-1:0]  dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    trial;
  logic          ge;
  logic [W:0]    diff;

  assign trial = {rem_r, dq_r[W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= '0;
        dq_r   <= dividend;
        dvs_r  <= divisor;
        cnt_r  <= CW'(W - 1);
      end else if (busy_r) begin
        rem_r <= ge ? diff[W-1:0] : trial[W-1:0];
        dq_r  <= {dq_r[W-2:0], ge};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = dq_r;
  assign rem  = rem_r;

endmodule

### rtl/core/ecsm_dpath.sv
// Datapath: working registers, modular add/sub, shared multiplier and divider, result register.
module ecsm_dpath import ecsm_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_load,
  input  ecsm_in_t    in_req,
  input  logic        cfg_wr,
  input  logic        cfg_sel_a,
  input  logic [63:0] cfg_wdata,
  output logic [63:0] n_val,
  output logic [63:0] a_val,
  input  ecsm_cmd_t   cmd,
  output ecsm_stat_t  stat,
  output logic        out_strobe,
  output ecsm_out_t   out_res
);

  localparam int W = WORD_BITS;

  logic [W-1:0] n_r, a_r, ix_r, iy_r;
  logic [W-1:0] px_r, py_r, bx_r, by_r, s_r, t_r, u_r;
  logic [W-1:0] r0_r, r1_r, t0_r, t1_r, q_r;
  logic         pinf_r;
  logic [4:0]   dst_r;
  logic         done_r;
  logic         out_strobe_r;
  ecsm_out_t    out_res_r;

  logic [W-1:0] opa, opb, alu;
  logic         mul_go, div_go, mul_done, div_done;
  logic [W-1:0] mul_prod, div_quot, div_rem;
  logic         wr_en;
  logic [4:0]   wr_sel;
  logic [W-1:0] wr_val;
  logic [W-1:0] cfg_w;

  function automatic logic [W-1:0] addm(input logic [W-1:0] p, input logic [W-1:0] q,
                                         input logic [W-1:0] n);
    logic [W:0] s;
    s = {1'b0, p} + {1'b0, q};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] subm(input logic [W-1:0] p, input logic [W-1:0] q,
                                         input logic [W-1:0] n);
    return (p >= q) ? (p - q) : (p + (n - q));
  endfunction

  always_comb begin
    unique case (cmd.src_a)
      R_PX:    opa = px_r;
      R_PY:    opa = py_r;
      R_BX:    opa = bx_r;
      R_BY:    opa = by_r;
      R_S:     opa = s_r;
      R_T:     opa = t_r;
      R_U:     opa = u_r;
      R_R0:    opa = r0_r;
      R_R1:    opa = r1_r;
      R_T0:    opa = t0_r;
      R_T1:    opa = t1_r;
      R_Q:     opa = q_r;
      R_A:     opa = a_r;
      R_N:     opa = n_r;
      R_ONE:   opa = W'(1);
      R_IX:    opa = ix_r;
      R_IY:    opa = iy_r;
      default: opa = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.src_b)
      R_PX:    opb = px_r;
      R_PY:    opb = py_r;
      R_BX:    opb = bx_r;
      R_BY:    opb = by_r;
      R_S:     opb = s_r;
      R_T:     opb = t_r;
      R_U:     opb = u_r;
      R_R0:    opb = r0_r;
      R_R1:    opb = r1_r;
      R_T0:    opb = t0_r;
      R_T1:    opb = t1_r;
      R_Q:     opb = q_r;
      R_A:     opb = a_r;
      R_N:     opb = n_r;
      R_ONE:   opb = W'(1);
      R_IX:    opb = ix_r;
      R_IY:    opb = iy_r;
      default: opb = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.op)
      OP_ADD:  alu = addm(opa, opb, n_r);
      OP_SUB:  alu = subm(opa, opb, n_r);
      default: alu = opa;
    endcase
  end

  assign mul_go = cmd.go && (cmd.op == OP_MUL);
  assign div_go = cmd.go && (cmd.op == OP_DIV);

  ecsm_mulmod #(.WORD_BITS(WORD_BITS)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_go),
    .op_a    (opa),
    .op_b    (opb),
    .modulus (n_r),
    .done    (mul_done),
    .prod    (mul_prod)
  );

  ecsm_divu #(.WORD_BITS(WORD_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (opa),
    .divisor  (opb),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // One write per cycle: an add, subtract or move at issue, or a unit on completion
  always_comb begin
    wr_en  = 1'b0;
    wr_sel = dst_r;
    wr_val = alu;
    if (cmd.go && (cmd.op == OP_ADD || cmd.op == OP_SUB || cmd.op == OP_MOV)) begin
      wr_en  = 1'b1;
      wr_sel = cmd.dst;
    end else if (mul_done) begin
      wr_en  = 1'b1;
      wr_val = mul_prod;
    end else if (div_done) begin
      wr_en  = 1'b1;
      wr_val = div_rem;
    end
  end

  assign cfg_w = cfg_wdata[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r          <= W'(3);
      a_r          <= '0;
      pinf_r       <= 1'b0;
      done_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      done_r       <= cmd.go && (cmd.op == OP_ADD || cmd.op == OP_SUB ||
                                 cmd.op == OP_MOV || cmd.op == OP_NOP);
      out_strobe_r <= cmd.go && (cmd.op == OP_OUTOK || cmd.op == OP_OUTFL);
      if (cmd.go && cmd.set_inf) pinf_r <= 1'b1;
      else if (cmd.go && cmd.clr_inf) pinf_r <= 1'b0;
      if (cfg_wr && !cfg_sel_a) n_r <= (cfg_w < W'(3)) ? W'(3) : cfg_w;
      if (cfg_wr && cfg_sel_a) a_r <= cfg_w;
      else if (wr_en && wr_sel == R_A) a_r <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      ix_r <= in_req.base_x[W-1:0];
      iy_r <= in_req.base_y[W-1:0];
    end
    if (cmd.go) dst_r <= cmd.dst;
    // in the gcd, a quotient of N is only possible for a unit denominator and reduces to zero
    if (div_done) q_r <= (div_quot == n_r) ? '0 : div_quot;
    if (wr_en) begin
      unique case (wr_sel)
        R_PX:    px_r <= wr_val;
        R_PY:    py_r <= wr_val;
        R_BX:    bx_r <= wr_val;
        R_BY:    by_r <= wr_val;
        R_S:     s_r  <= wr_val;
        R_T:     t_r  <= wr_val;
        R_U:     u_r  <= wr_val;
        R_R0:    r0_r <= wr_val;
        R_R1:    r1_r <= wr_val;
        R_T0:    t0_r <= wr_val;
        R_T1:    t1_r <= wr_val;
        default: ;
      endcase
    end
    if (cmd.go && cmd.op == OP_OUTOK) begin
      out_res_r.result_x     <= pinf_r ? 64'd0 : 64'(px_r);
      out_res_r.result_y     <= pinf_r ? 64'd0 : 64'(py_r);
      out_res_r.at_infinity  <= pinf_r;
      out_res_r.divisor      <= 64'd1;
      out_res_r.factor_found <= 1'b0;
    end else if (cmd.go && cmd.op == OP_OUTFL) begin
      out_res_r.result_x     <= 64'd0;
      out_res_r.result_y     <= 64'd0;
      out_res_r.at_infinity  <= 1'b0;
      out_res_r.divisor      <= 64'(r0_r);
      out_res_r.factor_found <= 1'b1;
    end
  end

  assign stat.done     = done_r | mul_done | div_done;
  assign stat.pinf     = pinf_r;
  assign stat.py_zero  = (py_r == '0);
  assign stat.px_eq_bx = (px_r == bx_r);
  assign stat.py_eq_by = (py_r == by_r);
  assign stat.r1_zero  = (r1_r == '0);
  assign stat.r0_one   = (r0_r == W'(1));

  assign n_val      = 64'(n_r);
  assign a_val      = 64'(a_r);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

### rtl/core/ecsm_ctrl.sv
// Controller: sequences reduction, double-and-add, point formulas and extended gcd.
module ecsm_ctrl import ecsm_pkg::*; #(
  parameter int SCALAR_BITS = SCALAR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [63:0] scalar,
  input  ecsm_stat_t stat,
  output ecsm_cmd_t  cmd,
  output logic       busy
);

  localparam int SB = SCALAR_BITS;
  localparam int TW = $clog2(SB);

  localparam logic [5:0] S_IDLE = 6'd0,  S_RX   = 6'd1,  S_RY   = 6'd2,  S_RA   = 6'd3;
  localparam logic [5:0] S_LPX  = 6'd4,  S_LPY  = 6'd5,  S_SCAN = 6'd6,  S_DBL  = 6'd7;
  localparam logic [5:0] S_SINF = 6'd8,  S_D1   = 6'd9,  S_G0   = 6'd10, S_G1   = 6'd11;
  localparam logic [5:0] S_G2   = 6'd12, S_G3   = 6'd13, S_GL   = 6'd14, S_G4   = 6'd15;
  localparam logic [5:0] S_G5   = 6'd16, S_G6   = 6'd17, S_G7   = 6'd18, S_G8   = 6'd19;
  localparam logic [5:0] S_G9   = 6'd20, S_G10  = 6'd21, S_GE   = 6'd22, S_D2   = 6'd23;
  localparam logic [5:0] S_D3   = 6'd24, S_D4   = 6'd25, S_D5   = 6'd26, S_D6   = 6'd27;
  localparam logic [5:0] S_D7   = 6'd28, S_D8   = 6'd29, S_D9   = 6'd30, S_C1   = 6'd31;
  localparam logic [5:0] S_C2   = 6'd32, S_C3   = 6'd33, S_C4   = 6'd34, S_AFT  = 6'd35;
  localparam logic [5:0] S_ADD  = 6'd36, S_A0   = 6'd37, S_A1   = 6'd38, S_AT   = 6'd39;
  localparam logic [5:0] S_A2   = 6'd40, S_A3   = 6'd41, S_A4   = 6'd42, S_A5   = 6'd43;
  localparam logic [5:0] S_A6   = 6'd44, S_FAIL = 6'd45, S_OUT  = 6'd46;

  logic [5:0]    state_r, state_nxt, after;
  logic          pend_r, pend_nxt;
  logic [SB-1:0] scal_r, scal_nxt;
  logic [TW-1:0] t_r, t_nxt;
  logic          slope_dbl_r, slope_dbl_nxt;
  logic          phase_add_r, phase_add_nxt;
  logic          exec;
  logic          bit_c;
  ecsm_cmd_t     c;

  function automatic ecsm_cmd_t mk(input logic [2:0] op, input logic [4:0] a,
                                   input logic [4:0] b, input logic [4:0] d);
    ecsm_cmd_t r;
    r = '0;
    r.op    = op;
    r.src_a = a;
    r.src_b = b;
    r.dst   = d;
    return r;
  endfunction

  assign bit_c = scal_r[t_r];

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    scal_nxt      = scal_r;
    t_nxt         = t_r;
    slope_dbl_nxt = slope_dbl_r;
    phase_add_nxt = phase_add_r;
    exec          = 1'b0;
    after         = state_r;
    c             = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          scal_nxt  = scalar[SB-1:0];
          t_nxt     = TW'(SB - 1);
          state_nxt = S_RX;
        end
      end
      S_RX:  begin c = mk(OP_DIV, R_IX, R_N, R_BX); exec = 1'b1; after = S_RY; end
      S_RY:  begin c = mk(OP_DIV, R_IY, R_N, R_BY); exec = 1'b1; after = S_RA; end
      S_RA:  begin c = mk(OP_DIV, R_A, R_N, R_A); exec = 1'b1; after = S_LPX; end
      S_LPX: begin c = mk(OP_MOV, R_BX, R_ZERO, R_PX); exec = 1'b1; after = S_LPY; end
      S_LPY: begin
        c = mk(OP_MOV, R_BY, R_ZERO, R_PY);
        c.clr_inf = 1'b1;
        exec = 1'b1;
        after = S_SCAN;
      end
      S_SCAN: begin
        // hunt for the leading one; the base point is the starting value
        if (t_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          t_nxt = t_r - 1'b1;
          if (bit_c) begin
            phase_add_nxt = 1'b0;
            state_nxt     = S_DBL;
          end
        end
      end
      S_DBL: begin
        slope_dbl_nxt = 1'b1;
        if (stat.pinf) state_nxt = S_AFT;
        else if (stat.py_zero) state_nxt = S_SINF;
        else state_nxt = S_D1;
      end
      S_SINF: begin
        c = mk(OP_NOP, R_ZERO, R_ZERO, R_ZERO);
        c.set_inf = 1'b1;
        exec = 1'b1;
        after = S_AFT;
      end
      S_D1:  begin c = mk(OP_ADD, R_PY, R_PY, R_T); exec = 1'b1; after = S_G0; end
      S_G0:  begin c = mk(OP_MOV, R_N, R_ZERO, R_R0); exec = 1'b1; after = S_G1; end
      S_G1:  begin c = mk(OP_MOV, R_T, R_ZERO, R_R1); exec = 1'b1; after = S_G2; end
      S_G2:  begin c = mk(OP_MOV, R_ZERO, R_ZERO, R_T0); exec = 1'b1; after = S_G3; end
      S_G3:  begin c = mk(OP_MOV, R_ONE, R_ZERO, R_T1); exec = 1'b1; after = S_GL; end
      S_GL:  state_nxt = stat.r1_zero ? S_GE : S_G4;
      S_G4:  begin c = mk(OP_DIV, R_R0, R_R1, R_U); exec = 1'b1; after = S_G5; end
      S_G5:  begin c = mk(OP_MUL, R_Q, R_T1, R_S); exec = 1'b1; after = S_G6; end
      S_G6:  begin c = mk(OP_SUB, R_T0, R_S, R_S); exec = 1'b1; after = S_G7; end
      S_G7:  begin c = mk(OP_MOV, R_R1, R_ZERO, R_R0); exec = 1'b1; after = S_G8; end
      S_G8:  begin c = mk(OP_MOV, R_U, R_ZERO, R_R1); exec = 1'b1; after = S_G9; end
      S_G9:  begin c = mk(OP_MOV, R_T1, R_ZERO, R_T0); exec = 1'b1; after = S_G10; end
      S_G10: begin c = mk(OP_MOV, R_S, R_ZERO, R_T1); exec = 1'b1; after = S_GL; end
      S_GE: begin
        if (!stat.r0_one) state_nxt = S_FAIL;
        else if (slope_dbl_r) state_nxt = S_D2;
        else state_nxt = S_A2;
      end
      S_D2:  begin c = mk(OP_MUL, R_PX, R_PX, R_S); exec = 1'b1; after = S_D3; end
      S_D3:  begin c = mk(OP_ADD, R_S, R_S, R_T); exec = 1'b1; after = S_D4; end
      S_D4:  begin c = mk(OP_ADD, R_T, R_S, R_T); exec = 1'b1; after = S_D5; end
      S_D5:  begin c = mk(OP_ADD, R_T, R_A, R_T); exec = 1'b1; after = S_D6; end
      S_D6:  begin c = mk(OP_MUL, R_T, R_T0, R_S); exec = 1'b1; after = S_D7; end
      S_D7:  begin c = mk(OP_MUL, R_S, R_S, R_T); exec = 1'b1; after = S_D8; end
      S_D8:  begin c = mk(OP_ADD, R_PX, R_PX, R_U); exec = 1'b1; after = S_D9; end
      S_D9:  begin c = mk(OP_SUB, R_T, R_U, R_T); exec = 1'b1; after = S_C1; end
      S_C1:  begin c = mk(OP_SUB, R_PX, R_T, R_U); exec = 1'b1; after = S_C2; end
      S_C2:  begin c = mk(OP_MUL, R_S, R_U, R_U); exec = 1'b1; after = S_C3; end
      S_C3:  begin c = mk(OP_SUB, R_U, R_PY, R_PY); exec = 1'b1; after = S_C4; end
      S_C4:  begin c = mk(OP_MOV, R_T, R_ZERO, R_PX); exec = 1'b1; after = S_AFT; end
      S_AFT: begin
        if (!phase_add_r && bit_c) begin
          phase_add_nxt = 1'b1;
          state_nxt     = S_ADD;
        end else if (t_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          t_nxt         = t_r - 1'b1;
          phase_add_nxt = 1'b0;
          state_nxt     = S_DBL;
        end
      end
      S_ADD: begin
        if (stat.pinf) begin
          state_nxt = S_A0;
        end else if (stat.px_eq_bx) begin
          state_nxt = stat.py_eq_by ? S_DBL : S_SINF;
        end else begin
          slope_dbl_nxt = 1'b0;
          state_nxt     = S_AT;
        end
      end
      S_A0:  begin c = mk(OP_MOV, R_BX, R_ZERO, R_PX); exec = 1'b1; after = S_A1; end
      S_A1: begin
        c = mk(OP_MOV, R_BY, R_ZERO, R_PY);
        c.clr_inf = 1'b1;
        exec = 1'b1;
        after = S_AFT;
      end
      S_AT:  begin c = mk(OP_SUB, R_BX, R_PX, R_T); exec = 1'b1; after = S_G0; end
      S_A2:  begin c = mk(OP_SUB, R_BY, R_PY, R_U); exec = 1'b1; after = S_A3; end
      S_A3:  begin c = mk(OP_MUL, R_U, R_T0, R_S); exec = 1'b1; after = S_A4; end
      S_A4:  begin c = mk(OP_MUL, R_S, R_S, R_T); exec = 1'b1; after = S_A5; end
      S_A5:  begin c = mk(OP_ADD, R_PX, R_BX, R_U); exec = 1'b1; after = S_A6; end
      S_A6:  begin c = mk(OP_SUB, R_T, R_U, R_T); exec = 1'b1; after = S_C1; end
      S_FAIL: begin
        c = mk(OP_OUTFL, R_ZERO, R_ZERO, R_ZERO);
        c.go = 1'b1;
        state_nxt = S_IDLE;
      end
      S_OUT: begin
        c = mk(OP_OUTOK, R_ZERO, R_ZERO, R_ZERO);
        c.go = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // issue once, then hold until the datapath reports completion
    if (exec) begin
      c.go = !pend_r;
      if (!pend_r) begin
        pend_nxt = 1'b1;
      end else if (stat.done) begin
        pend_nxt  = 1'b0;
        state_nxt = after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      slope_dbl_r <= 1'b0;
      phase_add_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      slope_dbl_r <= slope_dbl_nxt;
      phase_add_r <= phase_add_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scal_r <= scal_nxt;
    t_r    <= t_nxt;
  end

  assign cmd  = c;
  assign busy = (state_r != S_IDLE);

endmodule

### tb/ecsm_checker.sv
// Checker for the EC scalar multiplier: tracks config writes, predicts each request, compares.
`timescale 1ns / 100ps

module ecsm_checker import ecsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  ecsm_in_t              in_req,
  input  logic                  out_strobe,
  input  ecsm_out_t             out_res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [63:0]           pwdata,
  output int                    errors,
  output int                    pending,
  output int                    factor_hits,
  output int                    inf_results
);

  localparam logic [PADDR_BITS-1:0] ADDR_MODULUS = 4'd0;
  localparam logic [PADDR_BITS-1:0] ADDR_COEF_A  = 4'd8;

  typedef struct {
    logic [63:0] x;
    logic [63:0] y;
    logic        inf;
  } pt_t;

  logic [63:0] n_mod;
  logic [63:0] a_coef;
  ecsm_out_t   want_q[$];

  function automatic logic [63:0] madd(logic [63:0] p, logic [63:0] q, logic [63:0] n);
    logic [64:0] s;
    s = {1'b0, p} + {1'b0, q};
    return (s >= {1'b0, n}) ? 64'(s - {1'b0, n}) : s[63:0];
  endfunction

  function automatic logic [63:0] msub(logic [63:0] p, logic [63:0] q, logic [63:0] n);
    return (p >= q) ? p - q : p + (n - q);
  endfunction

  function automatic logic [63:0] mmul(logic [63:0] p, logic [63:0] q, logic [63:0] n);
    logic [127:0] prod;
    prod = {64'd0, p} * {64'd0, q};
    return 64'(prod % {64'd0, n});
  endfunction

  // Extended gcd of u against n; inv valid only when the gcd is 1.
  function automatic logic [63:0] gcd_inverse(logic [63:0] u, logic [63:0] n,
                                              output logic [63:0] inv);
    logic [63:0] r0, r1, t0, t1, q, rn, tn;
    r0 = n; r1 = u; t0 = 0; t1 = 1;
    while (r1 != 0) begin
      q  = r0 / r1;
      rn = r0 - q * r1;
      tn = msub(t0, mmul(q % n, t1, n), n);
      r0 = r1; r1 = rn; t0 = t1; t1 = tn;
    end
    inv = t0;
    return r0;
  endfunction

  function automatic logic [63:0] pt_double(inout pt_t p, input logic [63:0] a,
                                            input logic [63:0] n);
    logic [63:0] inv, d, s, x3, y3;
    if (p.inf) return 1;
    if (p.y == 0) begin
      p.inf = 1; p.x = 0; p.y = 0;
      return 1;
    end
    d = gcd_inverse(madd(p.y, p.y, n), n, inv);
    if (d != 1) return d;
    s  = mmul(p.x, p.x, n);
    s  = madd(madd(s, s, n), s, n);
    s  = mmul(madd(s, a, n), inv, n);
    x3 = msub(mmul(s, s, n), madd(p.x, p.x, n), n);
    y3 = msub(mmul(s, msub(p.x, x3, n), n), p.y, n);
    p.x = x3; p.y = y3;
    return 1;
  endfunction

  function automatic logic [63:0] pt_add(inout pt_t p, input pt_t b, input logic [63:0] a,
                                         input logic [63:0] n);
    logic [63:0] inv, d, s, x3, y3;
    if (p.inf) begin
      p = b;
      return 1;
    end
    if (p.x == b.x) begin
      if (p.y != b.y) begin
        p.inf = 1; p.x = 0; p.y = 0;
        return 1;
      end
      return pt_double(p, a, n);
    end
    d = gcd_inverse(msub(b.x, p.x, n), n, inv);
    if (d != 1) return d;
    s  = mmul(msub(b.y, p.y, n), inv, n);
    x3 = msub(mmul(s, s, n), madd(p.x, b.x, n), n);
    y3 = msub(mmul(s, msub(p.x, x3, n), n), p.y, n);
    p.x = x3; p.y = y3;
    return 1;
  endfunction

  function automatic ecsm_out_t scalar_multiple(ecsm_in_t req, logic [63:0] a,
                                                logic [63:0] n);
    pt_t         base, acc;
    logic [63:0] d;
    int          top;
    ecsm_out_t   r;
    d = 1;
    top = -1;
    base.x = req.base_x % n;
    base.y = req.base_y % n;
    base.inf = 0;
    acc = base;
    for (int t = 63; t >= 0; t--) begin
      if (req.scalar[t]) begin
        top = t;
        break;
      end
    end
    for (int t = top - 1; t >= 0; t--) begin
      d = pt_double(acc, a, n);
      if (d != 1) break;
      if (req.scalar[t]) begin
        d = pt_add(acc, base, a, n);
        if (d != 1) break;
      end
    end
    if (d != 1) begin
      r = '{result_x: 0, result_y: 0, at_infinity: 0, divisor: d, factor_found: 1};
    end else begin
      r.result_x     = acc.inf ? 64'd0 : acc.x;
      r.result_y     = acc.inf ? 64'd0 : acc.y;
      r.at_infinity  = acc.inf;
      r.divisor      = 1;
      r.factor_found = 0;
    end
    return r;
  endfunction

  assign pending = want_q.size();

  always @(posedge clk) begin
    ecsm_out_t want;
    if (!rst_n) begin
      n_mod  <= 3;
      a_coef <= 0;
      errors <= 0;
      factor_hits <= 0;
      inf_results <= 0;
      want_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_MODULUS) n_mod <= (pwdata < 3) ? 64'd3 : pwdata;
        else if (paddr == ADDR_COEF_A) a_coef <= pwdata;
      end
      if (start && !busy) begin
        // the coefficient is folded into the current modulus and kept that way
        a_coef <= a_coef % n_mod;
        want_q.push_back(scalar_multiple(in_req, a_coef % n_mod, n_mod));
      end
      if (out_strobe) begin
        if (want_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("ERROR: result with no request outstanding: %p", out_res);
        end else begin
          want = want_q.pop_front();
          if (want.factor_found) factor_hits <= factor_hits + 1;
          if (want.at_infinity) inf_results <= inf_results + 1;
          if (out_res.result_x !== want.result_x || out_res.result_y !== want.result_y ||
              out_res.at_infinity !== want.at_infinity || out_res.divisor !== want.divisor ||
              out_res.factor_found !== want.factor_found) begin
            errors <= errors + 1;
            if (errors < 10) begin
              $display("ERROR: mismatch at %0t", $realtime);
              $display("  expected x=%h y=%h inf=%b d=%h f=%b", want.result_x,
                       want.result_y, want.at_infinity, want.divisor, want.factor_found);
              $display("  actual   x=%h y=%h inf=%b d=%h f=%b", out_res.result_x,
                       out_res.result_y, out_res.at_infinity, out_res.divisor,
                       out_res.factor_found);
            end
          end
        end
      end
    end
  end

endmodule

### tb/testbench.sv
// Top of the EC scalar multiplier testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import ecsm_pkg::*;

  localparam logic [PADDR_BITS-1:0] ADDR_MODULUS = 4'd0;
  localparam logic [PADDR_BITS-1:0] ADDR_COEF_A  = 4'd8;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  start = 0;
  logic                  busy;
  ecsm_in_t              in_req = '0;
  logic                  out_strobe;
  ecsm_out_t             out_res;
  logic                  psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [63:0]           pwdata = '0;
  logic [63:0]           prdata;
  logic                  pready;
  int                    errors, pending, factor_hits, inf_results;
  int                    sent = 0;
  int                    idle_pct;

  weierstrass_scalar_multiply_mod_n dut (
    .clk, .rst_n, .start, .busy, .in_req, .out_strobe, .out_res,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ecsm_checker chk (
    .clk, .rst_n, .start, .busy, .in_req, .out_strobe, .out_res,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .pending, .factor_hits, .inf_results
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #(64'd400_000_000);
    $display("ERROR: timeout");
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic reg_write(logic [PADDR_BITS-1:0] addr, logic [63:0] value);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    // bus returns to idle between transfers
    @(posedge clk);
  endtask

  // Hold the request until the block takes it, then maybe drop start for a gap.
  task automatic send_req(logic [63:0] m, logic [63:0] bx, logic [63:0] by);
    start  <= 1;
    in_req <= '{scalar: m, base_x: bx, base_y: by};
    do @(posedge clk); while (busy);
    sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [63:0] n, logic [63:0] a);
    drain();
    reg_write(ADDR_MODULUS, n);
    reg_write(ADDR_COEF_A, a);
  endtask

  task automatic random_phase(int count);
    logic [63:0] m;
    for (int i = 0; i < count; i++) begin
      // mostly short scalars; a rare one is a random full-width value
      if ($urandom_range(19) == 0) m = rand64();
      else m = 64'($urandom_range(0, 40));
      send_req(m, rand64(), ($urandom_range(7) == 0) ? 64'd0 : rand64());
      if (i == count / 2 && $urandom_range(1) == 1) drain();
    end
  endtask

  initial begin
    idle_pct = 17;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset settings: N = 3, a = 0
    send_req(64'd0, '1, '1);
    send_req(64'd1, 64'd5, 64'd7);
    send_req(64'd2, 64'd1, 64'd0);
    send_req(64'd3, 64'd2, 64'd3);
    send_req(64'd7, 64'd1, 64'd1);

    // a modulus below 3 saturates
    configure(64'd0, '1);
    send_req(64'd5, 64'd1, 64'd2);
    configure('1, '1);
    send_req('1, 64'd2, 64'd3);
    send_req(64'h8000_0000_0000_0001, '1, 64'd6);
    configure(64'd15, 64'd1);
    for (int i = 0; i < 8; i++) send_req(64'(i + 2), 64'($urandom_range(14)),
                                          64'($urandom_range(14)));
    configure(64'hFFFF_FFFF_FFFF_FFC5, 64'd3);
    send_req(64'd5, 64'd2, 64'h1234_5678_9ABC_DEF0);
    send_req(64'd12, rand64(), rand64());
    configure(64'd11, 64'd0);
    send_req(64'hAAAA_AAAA_5555_5555, 64'd3, 64'd4);
    send_req(64'd4, 64'd0, 64'd10);

    // the pause that lets everything drain
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      idle_pct = (mode == 0) ? 17 : (mode == 1) ? 62 : 0;
      configure(64'($urandom_range(3, 4000)), rand64());
      random_phase(13);
      configure(64'($urandom_range(5, 60000)), 64'($urandom_range(0, 9)));
      random_phase(13);
    end

    drain();
    repeat (50) @(posedge clk);
    $display("Covered %0d requests over several moduli and coefficients; %0d factor hits,",
             sent, factor_hits);
    $display("%0d results at infinity, with sender gaps varied across phases.", inf_results);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
